// File: rtl/core/ray_box_slab_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray/box slab test unit
// Property forms for the concurrent checks in ray_box_slab_test_unit.sv.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbst check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define RBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbst check failed (next cycle)");

`endif

// File: rtl/core/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and control types of the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_X   = 0;
  localparam int AXIS_Y   = 1;
  localparam int AXIS_Z   = 2;

  // Per-stage control: en lets the stage register load, vld marks the
  // incoming data as a real transaction rather than a bubble.
  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctl_t;

endpackage

// File: rtl/core/rbst_if.sv
// ----------------------------------------------------------------------------
// rbst_box_if / rbst_hit_if
// Valid/ready channels carrying a box test request and its hit result.
// ----------------------------------------------------------------------------
interface rbst_box_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_x_min;
  logic signed [COORD_WIDTH-1:0] box_x_max;
  logic signed [COORD_WIDTH-1:0] box_y_min;
  logic signed [COORD_WIDTH-1:0] box_y_max;
  logic signed [COORD_WIDTH-1:0] box_z_min;
  logic signed [COORD_WIDTH-1:0] box_z_max;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] inv_x;
  logic signed [COORD_WIDTH-1:0] inv_y;
  logic signed [COORD_WIDTH-1:0] inv_z;

  modport source (
    output valid, box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max,
           origin_x, origin_y, origin_z, inv_x, inv_y, inv_z,
    input  ready
  );
  modport sink (
    input  valid, box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max,
           origin_x, origin_y, origin_z, inv_x, inv_y, inv_z,
    output ready
  );
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

// File: rtl/core/rbst_axis_prep.sv
// ----------------------------------------------------------------------------
// rbst_axis_prep
// Stage 1 for one axis: picks near/far planes by the inverse sign and
// subtracts the ray origin from each.
// ----------------------------------------------------------------------------
module rbst_axis_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  rbst_pkg::stage_ctl_t          ctl,
  input  logic signed [COORD_WIDTH-1:0] plane_lo,
  input  logic signed [COORD_WIDTH-1:0] plane_hi,
  input  logic signed [COORD_WIDTH-1:0] origin,
  input  logic signed [COORD_WIDTH-1:0] inv,
  output logic signed [COORD_WIDTH:0]   near_d_r,
  output logic signed [COORD_WIDTH:0]   far_d_r,
  output logic signed [COORD_WIDTH-1:0] inv_r
);
  import rbst_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic                          inv_neg;
  logic signed [COORD_WIDTH-1:0] near_plane;
  logic signed [COORD_WIDTH-1:0] far_plane;
  logic signed [COORD_WIDTH:0]   near_d_nxt;
  logic signed [COORD_WIDTH:0]   far_d_nxt;

  // A negative inverse swaps the slab planes; zero counts as positive.
  assign inv_neg    = inv[COORD_WIDTH-1];
  assign near_plane = inv_neg ? plane_hi : plane_lo;
  assign far_plane  = inv_neg ? plane_lo : plane_hi;
  assign near_d_nxt = DW'(near_plane) - DW'(origin);
  assign far_d_nxt  = DW'(far_plane) - DW'(origin);

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.vld) begin
      near_d_r <= near_d_nxt;
      far_d_r  <= far_d_nxt;
      inv_r    <= inv;
    end
  end

endmodule

// File: rtl/core/rbst_slab_mul.sv
// ----------------------------------------------------------------------------
// rbst_slab_mul
// Stage 2 for one axis: full-width slab parameters (plane - origin) * inverse.
// ----------------------------------------------------------------------------
module rbst_slab_mul #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  rbst_pkg::stage_ctl_t            ctl,
  input  logic signed [COORD_WIDTH:0]     near_d,
  input  logic signed [COORD_WIDTH:0]     far_d,
  input  logic signed [COORD_WIDTH-1:0]   inv,
  output logic signed [2*COORD_WIDTH:0]   t_near_r,
  output logic signed [2*COORD_WIDTH:0]   t_far_r
);
  import rbst_pkg::*;

  localparam int TW = 2 * COORD_WIDTH + 1;

  logic signed [TW-1:0] t_near_nxt;
  logic signed [TW-1:0] t_far_nxt;

  // Signed product is exact in TW bits; no rounding or scaling is applied.
  assign t_near_nxt = TW'(near_d) * TW'(inv);
  assign t_far_nxt  = TW'(far_d) * TW'(inv);

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.vld) begin
      t_near_r <= t_near_nxt;
      t_far_r  <= t_far_nxt;
    end
  end

endmodule

// File: rtl/core/rbst_overlap.sv
// ----------------------------------------------------------------------------
// rbst_overlap
// Stages 3 and 4: intersects the x and y intervals, then tests z against
// the result and registers the hit flag.
// ----------------------------------------------------------------------------
module rbst_overlap #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  rbst_pkg::stage_ctl_t          ctl_xy,
  input  rbst_pkg::stage_ctl_t          ctl_z,
  input  logic signed [2*COORD_WIDTH:0] tn_x,
  input  logic signed [2*COORD_WIDTH:0] tf_x,
  input  logic signed [2*COORD_WIDTH:0] tn_y,
  input  logic signed [2*COORD_WIDTH:0] tf_y,
  input  logic signed [2*COORD_WIDTH:0] tn_z,
  input  logic signed [2*COORD_WIDTH:0] tf_z,
  output logic                          hit_r
);
  import rbst_pkg::*;

  localparam int TW = 2 * COORD_WIDTH + 1;

  logic signed [TW-1:0] tmin_nxt, tmax_nxt;
  logic                 reject_nxt;
  logic signed [TW-1:0] tmin_r, tmax_r, tn_z_r, tf_z_r;
  logic                 reject_r;
  logic                 hit_nxt;

  // Only strictly separated intervals are rejected.
  assign reject_nxt = (tn_x > tf_y) || (tn_y > tf_x);
  assign tmin_nxt   = (tn_y > tn_x) ? tn_y : tn_x;
  assign tmax_nxt   = (tf_x > tf_y) ? tf_y : tf_x;

  always_ff @(posedge clk) begin
    if (ctl_xy.en && ctl_xy.vld) begin
      tmin_r   <= tmin_nxt;
      tmax_r   <= tmax_nxt;
      tn_z_r   <= tn_z;
      tf_z_r   <= tf_z;
      reject_r <= reject_nxt;
    end
  end

  assign hit_nxt = !reject_r && !(tmin_r > tf_z_r) && !(tn_z_r > tmax_r);

  always_ff @(posedge clk) begin
    if (ctl_z.en && ctl_z.vld) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// File: rtl/core/ray_box_slab_test_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Pipelined ray versus axis-aligned box slab test, one result per request.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_box carries a box (min/max per axis), a ray
// origin and the per-axis inverse direction, all signed fixed point of
// COORD_WIDTH bits. Each accepted transaction yields exactly one transaction
// on out_res whose hit bit tells whether the ray line crosses the box; hits
// behind the origin are reported as hits.
// Pipeline: an accepted transaction passes through plane select and
// subtract, multiply, x/y interval merge, and the z test into the output
// register, which presents it on out_res.
// Throughput: one transaction per cycle unless out_res stalls; the multiply
// stage of six full-width products is the widest path and sets the clock.
// Reset: rst_n is synchronous and active low; it empties the pipeline, so
// out_res.valid is low and in_box.ready is high after reset.
// Stall: when out_res.ready is low, the stages fill up behind the held
// result; in_box.ready stays high until every stage holds a transaction,
// so bubbles are squeezed out and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_unit_defines.svh"

module ray_box_slab_test_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  rbst_box_if.sink      in_box,
  rbst_hit_if.source    out_res
);
  import rbst_pkg::*;

  // Valid bits of stage 1 (prep), stage 2 (multiply) and stage 3 (x/y merge);
  // stage 4 is the output register itself.
  logic [2:0] vld_r;
  logic       out_vld_r;
  logic [2:0] vld_nxt;
  logic       out_vld_nxt;

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic en_out;
  logic [2:0] en;
  logic in_acc;

  assign en_out = !out_vld_r || out_res.ready;
  assign en[2]  = !vld_r[2] || en_out;
  assign en[1]  = !vld_r[1] || en[2];
  assign en[0]  = !vld_r[0] || en[1];

  assign in_box.ready  = en[0];
  assign in_acc        = in_box.valid && en[0];
  assign out_res.valid = out_vld_r;

  assign vld_nxt[0]  = en[0]  ? in_acc   : vld_r[0];
  assign vld_nxt[1]  = en[1]  ? vld_r[0] : vld_r[1];
  assign vld_nxt[2]  = en[2]  ? vld_r[1] : vld_r[2];
  assign out_vld_nxt = en_out ? vld_r[2] : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  stage_ctl_t ctl_prep, ctl_mul, ctl_xy, ctl_z;

  assign ctl_prep = '{en: en[0], vld: in_box.valid};
  assign ctl_mul  = '{en: en[1], vld: vld_r[0]};
  assign ctl_xy   = '{en: en[2], vld: vld_r[1]};
  assign ctl_z    = '{en: en_out, vld: vld_r[2]};

  // Per-axis views of the request.
  logic signed [COORD_WIDTH-1:0] plane_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] plane_hi [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] origin   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] inv      [NUM_AXES];

  assign plane_lo[AXIS_X] = in_box.box_x_min;
  assign plane_hi[AXIS_X] = in_box.box_x_max;
  assign plane_lo[AXIS_Y] = in_box.box_y_min;
  assign plane_hi[AXIS_Y] = in_box.box_y_max;
  assign plane_lo[AXIS_Z] = in_box.box_z_min;
  assign plane_hi[AXIS_Z] = in_box.box_z_max;
  assign origin[AXIS_X]   = in_box.origin_x;
  assign origin[AXIS_Y]   = in_box.origin_y;
  assign origin[AXIS_Z]   = in_box.origin_z;
  assign inv[AXIS_X]      = in_box.inv_x;
  assign inv[AXIS_Y]      = in_box.inv_y;
  assign inv[AXIS_Z]      = in_box.inv_z;

  logic signed [COORD_WIDTH:0]   near_d [NUM_AXES];
  logic signed [COORD_WIDTH:0]   far_d  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] inv_s1 [NUM_AXES];
  logic signed [2*COORD_WIDTH:0] t_near [NUM_AXES];
  logic signed [2*COORD_WIDTH:0] t_far  [NUM_AXES];

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    rbst_axis_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
      .clk      (clk),
      .ctl      (ctl_prep),
      .plane_lo (plane_lo[ax]),
      .plane_hi (plane_hi[ax]),
      .origin   (origin[ax]),
      .inv      (inv[ax]),
      .near_d_r (near_d[ax]),
      .far_d_r  (far_d[ax]),
      .inv_r    (inv_s1[ax])
    );

    rbst_slab_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
      .clk      (clk),
      .ctl      (ctl_mul),
      .near_d   (near_d[ax]),
      .far_d    (far_d[ax]),
      .inv      (inv_s1[ax]),
      .t_near_r (t_near[ax]),
      .t_far_r  (t_far[ax])
    );
  end

  rbst_overlap #(.COORD_WIDTH(COORD_WIDTH)) u_overlap (
    .clk    (clk),
    .ctl_xy (ctl_xy),
    .ctl_z  (ctl_z),
    .tn_x   (t_near[AXIS_X]),
    .tf_x   (t_far[AXIS_X]),
    .tn_y   (t_near[AXIS_Y]),
    .tf_y   (t_far[AXIS_Y]),
    .tn_z   (t_near[AXIS_Z]),
    .tf_z   (t_far[AXIS_Z]),
    .hit_r  (out_res.hit)
  );

  // An accepted transaction always lands in stage 1.
  `RBST_ASSERT_NEXT(a_accept_loads_s1, clk, rst_n, in_acc, vld_r[0])
  // A stage-3 transaction blocked by a held result stays in place.
  `RBST_ASSERT_NEXT(a_s3_holds_on_stall, clk, rst_n, vld_r[2] && !en_out, vld_r[2])
  // A full pipeline behind a stalled output takes no new transaction.
  `RBST_ASSERT_SAME(a_full_blocks_input, clk, rst_n,
                    (&vld_r) && out_vld_r && !out_res.ready, !in_box.ready)

endmodule
